FILE: rtl/gff_pkg.sv
// Shared constants, types and a helper function for the grid flood-fill block.
package gff_pkg;

  // Grid geometry.
  localparam int GRID_DIM   = 24;
  localparam int CELL_COUNT = GRID_DIM * GRID_DIM;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int COORD_W = 5;
  localparam int COLOR_W = 2;
  localparam int COUNT_W = 10;
  localparam int QUEUE_W = 2 * COORD_W;

  // Command modes.
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd2;

  // Eight neighbor offsets: left, right, up, down, then the four diagonals.
  localparam int STEP_COUNT = 8;
  localparam int STEP_AW    = $clog2(STEP_COUNT);
  localparam logic [STEP_AW-1:0] STEP_LAST = STEP_AW'(STEP_COUNT - 1);
  localparam logic signed [1:0] STEP_ROW [STEP_COUNT] = '{0, 0, -1, 1, -1, -1, 1, 1};
  localparam logic signed [1:0] STEP_COL [STEP_COUNT] = '{-1, 1, 0, 0, -1, 1, -1, 1};

  // One command word as taken from the input channel.
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  // Memory port requests.
  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] addr;
    logic [COLOR_W-1:0] wdata;
  } color_req_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] addr;
    logic               wdata;
  } vis_req_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] addr;
    logic [QUEUE_W-1:0] wdata;
  } queue_req_t;

  // Status from the walk sequencer to the channel logic.
  typedef struct packed {
    logic               idle;
    logic               done;
    logic [COLOR_W-1:0] read_color;
    logic [COUNT_W-1:0] filled_count;
  } status_t;

  // Linear cell address of a row and column.
  function automatic logic [CELL_AW-1:0] cell_index(input logic [COORD_W-1:0] row,
                                                    input logic [COORD_W-1:0] col);
    return CELL_AW'(CELL_AW'(row) * CELL_AW'(GRID_DIM) + CELL_AW'(col));
  endfunction

endpackage

FILE: rtl/gff_ram.sv
// Generic single-port synchronous RAM with a registered read.
module gff_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/gff_walk.sv
// Sequencer for cell access and the breadth-first 8-connected fill walk.
module gff_walk (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  gff_pkg::cmd_t                 cmd,
  input  logic                          res_ready,
  output gff_pkg::status_t              status,
  output gff_pkg::color_req_t           color_req,
  output gff_pkg::vis_req_t             vis_req,
  output gff_pkg::queue_req_t           queue_req,
  input  logic [gff_pkg::COLOR_W-1:0]   color_rdata,
  input  logic                          vis_rdata,
  input  logic [gff_pkg::QUEUE_W-1:0]   queue_rdata
);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_SEED  = 4'd3;
  localparam logic [3:0] S_CLR   = 4'd4;
  localparam logic [3:0] S_START = 4'd5;
  localparam logic [3:0] S_DEQ   = 4'd6;
  localparam logic [3:0] S_POP   = 4'd7;
  localparam logic [3:0] S_OWN   = 4'd8;
  localparam logic [3:0] S_NB    = 4'd9;
  localparam logic [3:0] S_CHK   = 4'd10;
  localparam logic [3:0] S_PAINT = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  localparam logic [gff_pkg::CELL_AW-1:0] SWEEP_LAST =
    gff_pkg::CELL_AW'(gff_pkg::CELL_COUNT - 1);
  localparam logic [gff_pkg::COORD_W-1:0] EDGE_LAST =
    gff_pkg::COORD_W'(gff_pkg::GRID_DIM - 1);

  logic [3:0]                      state;
  logic [gff_pkg::CELL_AW-1:0]     sweep;
  logic [gff_pkg::CELL_AW:0]       head;
  logic [gff_pkg::CELL_AW:0]       tail;
  logic [gff_pkg::CELL_AW:0]       count;
  logic [gff_pkg::STEP_AW-1:0]     k;
  logic [gff_pkg::COORD_W-1:0]     seed_r;
  logic [gff_pkg::COORD_W-1:0]     seed_c;
  logic [gff_pkg::COORD_W-1:0]     here_r;
  logic [gff_pkg::COORD_W-1:0]     here_c;
  logic [gff_pkg::COORD_W-1:0]     nb_r_q;
  logic [gff_pkg::COORD_W-1:0]     nb_c_q;
  logic [gff_pkg::COLOR_W-1:0]     paint;
  logic [gff_pkg::COLOR_W-1:0]     own;
  logic [gff_pkg::COLOR_W-1:0]     res_color;
  logic [gff_pkg::COUNT_W-1:0]     res_count;

  logic                            on_grid;
  logic signed [1:0]               dr;
  logic signed [1:0]               dc;
  logic [gff_pkg::COORD_W-1:0]     nb_r;
  logic [gff_pkg::COORD_W-1:0]     nb_c;
  logic                            nb_ok;
  logic                            hit;

  // Command decode and neighbor arithmetic.
  always_comb begin
    on_grid = (cmd.row < gff_pkg::COORD_W'(gff_pkg::GRID_DIM)) &&
              (cmd.col < gff_pkg::COORD_W'(gff_pkg::GRID_DIM));
    dr      = gff_pkg::STEP_ROW[k];
    dc      = gff_pkg::STEP_COL[k];
    nb_r    = here_r + {{(gff_pkg::COORD_W-2){dr[1]}}, dr};
    nb_c    = here_c + {{(gff_pkg::COORD_W-2){dc[1]}}, dc};
    nb_ok   = !(dr == -2'sd1 && here_r == '0) && !(dr == 2'sd1 && here_r == EDGE_LAST) &&
              !(dc == -2'sd1 && here_c == '0) && !(dc == 2'sd1 && here_c == EDGE_LAST);
    hit     = (color_rdata == own) && !vis_rdata;
  end

  // Memory requests for the current step.
  always_comb begin
    color_req = '0;
    vis_req   = '0;
    queue_req = '0;
    case (state)
      S_INIT: begin
        color_req.we   = 1'b1;
        color_req.addr = sweep;
        vis_req.we     = 1'b1;
        vis_req.addr   = sweep;
      end
      S_IDLE: begin
        color_req.addr  = gff_pkg::cell_index(cmd.row, cmd.col);
        color_req.wdata = cmd.color;
        color_req.we    = start && on_grid && (cmd.mode == gff_pkg::MODE_WRITE);
      end
      S_CLR: begin
        vis_req.we   = 1'b1;
        vis_req.addr = sweep;
      end
      S_START: begin
        vis_req.we      = 1'b1;
        vis_req.addr    = gff_pkg::cell_index(seed_r, seed_c);
        vis_req.wdata   = 1'b1;
        queue_req.we    = 1'b1;
        queue_req.wdata = {seed_r, seed_c};
      end
      S_DEQ: begin
        queue_req.addr = head[gff_pkg::CELL_AW-1:0];
      end
      S_POP: begin
        color_req.addr = gff_pkg::cell_index(queue_rdata[gff_pkg::QUEUE_W-1:gff_pkg::COORD_W],
                                             queue_rdata[gff_pkg::COORD_W-1:0]);
      end
      S_NB: begin
        color_req.addr = gff_pkg::cell_index(nb_r, nb_c);
        vis_req.addr   = gff_pkg::cell_index(nb_r, nb_c);
      end
      S_CHK: begin
        vis_req.we      = hit;
        vis_req.addr    = gff_pkg::cell_index(nb_r_q, nb_c_q);
        vis_req.wdata   = 1'b1;
        queue_req.we    = hit;
        queue_req.addr  = tail[gff_pkg::CELL_AW-1:0];
        queue_req.wdata = {nb_r_q, nb_c_q};
      end
      S_PAINT: begin
        color_req.we    = 1'b1;
        color_req.addr  = gff_pkg::cell_index(here_r, here_c);
        color_req.wdata = paint;
      end
      default: begin
      end
    endcase
  end

  // Control state: clearing sweeps, command dispatch and the walk itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      sweep <= '0;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_INIT: begin
          if (sweep == SWEEP_LAST) begin
            sweep <= '0;
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            seed_r    <= cmd.row;
            seed_c    <= cmd.col;
            paint     <= cmd.color;
            res_color <= '0;
            res_count <= '0;
            if (!on_grid) begin
              state <= S_DONE;
            end else begin
              case (cmd.mode)
                gff_pkg::MODE_READ: state <= S_RD;
                gff_pkg::MODE_FILL: state <= S_SEED;
                default:            state <= S_DONE;
              endcase
            end
          end
        end
        S_RD: begin
          res_color <= color_rdata;
          state     <= S_DONE;
        end
        S_SEED: begin
          // A fill with the seed's own color changes nothing.
          if (color_rdata == paint) begin
            state <= S_DONE;
          end else begin
            sweep <= '0;
            state <= S_CLR;
          end
        end
        S_CLR: begin
          if (sweep == SWEEP_LAST) begin
            sweep <= '0;
            state <= S_START;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_START: begin
          head  <= '0;
          tail  <= (gff_pkg::CELL_AW+1)'(1);
          count <= '0;
          state <= S_DEQ;
        end
        S_DEQ: begin
          if (head == tail) begin
            res_count <= gff_pkg::COUNT_W'(count);
            state     <= S_DONE;
          end else begin
            head  <= head + 1'b1;
            state <= S_POP;
          end
        end
        S_POP: begin
          here_r <= queue_rdata[gff_pkg::QUEUE_W-1:gff_pkg::COORD_W];
          here_c <= queue_rdata[gff_pkg::COORD_W-1:0];
          state  <= S_OWN;
        end
        S_OWN: begin
          own   <= color_rdata;
          k     <= '0;
          state <= S_NB;
        end
        S_NB: begin
          if (nb_ok) begin
            nb_r_q <= nb_r;
            nb_c_q <= nb_c;
            state  <= S_CHK;
          end else if (k == gff_pkg::STEP_LAST) begin
            state <= S_PAINT;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_CHK: begin
          if (hit) begin
            tail <= tail + 1'b1;
          end
          if (k == gff_pkg::STEP_LAST) begin
            state <= S_PAINT;
          end else begin
            k     <= k + 1'b1;
            state <= S_NB;
          end
        end
        S_PAINT: begin
          count <= count + 1'b1;
          state <= S_DEQ;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Status toward the channel logic.
  always_comb begin
    status.idle         = (state == S_IDLE);
    status.done         = (state == S_DONE);
    status.read_color   = res_color;
    status.filled_count = res_count;
  end

  // The queue never holds more than every cell once.
  assert property (@(posedge clk) disable iff (rst)
    (head <= tail) && (tail <= (gff_pkg::CELL_AW+1)'(gff_pkg::CELL_COUNT)))
    else $error("walk queue pointers out of range");

  // Every recolored cell was dequeued first.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_INIT) |-> (count <= head))
    else $error("fill count ahead of dequeued cells");

  // Marking a cell visited always enqueues it.
  assert property (@(posedge clk) disable iff (rst)
    (vis_req.we && vis_req.wdata) |-> queue_req.we)
    else $error("cell marked visited without being enqueued");

  // A dequeue happens only while the queue holds cells.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> ($past(head) < $past(tail)))
    else $error("dequeue from an empty walk queue");

endmodule

FILE: rtl/grid_flood_fill_8conn.sv
// Top level of the grid flood-fill block: stream channels, output register and memories.
//
// Usage: each input word on s_axis carries one command (write a cell, read a cell, or
// flood fill from a seed cell with 8-connectivity on a 24 by 24 grid of 2-bit colors).
// Every command yields exactly one output word on m_axis: the read color for a read,
// the number of recolored cells for a fill, and zero otherwise. Commands with a row or
// column off the grid, or with the unused mode, change nothing and return zero.
// A fill whose color already matches the seed cell is skipped; otherwise the fill time
// is set by the visited-map clear sweep (one entry a cycle) and by the single port of
// the color memory, probed once per neighbor with a registered read.
// One command is in work at a time; s_axis_tready is high while the sequencer is idle.
// After reset a sweep clears the color and visited memories, with s_axis_tready low.
// A finished result sits in the output register while the next command is taken; if
// the receiver stalls with that register still full, the next result waits in the
// sequencer and no further command is accepted.
module grid_flood_fill_8conn (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // mode[1:0], row[6:2], col[11:7], color[13:12], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // read_color[1:0], filled_count[11:2], zero
);

  gff_pkg::cmd_t                   cmd;
  gff_pkg::status_t                status;
  gff_pkg::color_req_t             color_req;
  gff_pkg::vis_req_t               vis_req;
  gff_pkg::queue_req_t             queue_req;
  logic [gff_pkg::COLOR_W-1:0]     color_rdata;
  logic                            vis_rdata;
  logic [gff_pkg::QUEUE_W-1:0]     queue_rdata;
  logic                            start;
  logic                            res_ready;
  logic                            out_valid;
  logic [15:0]                     out_data;

  // Unpack the input word.
  always_comb begin
    cmd.mode  = s_axis_tdata[1:0];
    cmd.row   = s_axis_tdata[6:2];
    cmd.col   = s_axis_tdata[11:7];
    cmd.color = s_axis_tdata[13:12];
  end

  assign s_axis_tready = status.idle;
  assign start         = s_axis_tvalid && status.idle;
  assign res_ready     = !out_valid || m_axis_tready;

  // Output register: loads a finished result when empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.done && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.done && res_ready) begin
      out_data <= {4'b0, status.filled_count, status.read_color};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Sequencer.
  gff_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .res_ready   (res_ready),
    .status      (status),
    .color_req   (color_req),
    .vis_req     (vis_req),
    .queue_req   (queue_req),
    .color_rdata (color_rdata),
    .vis_rdata   (vis_rdata),
    .queue_rdata (queue_rdata)
  );

  // Cell colors.
  gff_ram #(
    .WIDTH (gff_pkg::COLOR_W),
    .DEPTH (gff_pkg::CELL_COUNT)
  ) u_color_ram (
    .clk   (clk),
    .we    (color_req.we),
    .addr  (color_req.addr),
    .wdata (color_req.wdata),
    .rdata (color_rdata)
  );

  // Visited map.
  gff_ram #(
    .WIDTH (1),
    .DEPTH (gff_pkg::CELL_COUNT)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_req.we),
    .addr  (vis_req.addr),
    .wdata (vis_req.wdata),
    .rdata (vis_rdata)
  );

  // Walk queue of cell coordinates.
  gff_ram #(
    .WIDTH (gff_pkg::QUEUE_W),
    .DEPTH (gff_pkg::CELL_COUNT)
  ) u_queue_ram (
    .clk   (clk),
    .we    (queue_req.we),
    .addr  (queue_req.addr),
    .wdata (queue_req.wdata),
    .rdata (queue_rdata)
  );

endmodule

FILE: test/grid_flood_fill_8conn_test.sv
// Self-checking testbench for the 8-connected grid flood-fill block.
module grid_flood_fill_8conn_test;

  // The mode value that the block leaves unused.
  localparam logic [gff_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  // Neighbor offsets: left, right, up, down, then the four diagonals.
  localparam int ROW_STEP [8] = '{0, 0, -1, 1, -1, -1, 1, 1};
  localparam int COL_STEP [8] = '{-1, 1, 0, 0, -1, 1, -1, 1};

  // Fields of one result word.
  typedef struct packed {
    logic [gff_pkg::COUNT_W-1:0] filled_count;
    logic [gff_pkg::COLOR_W-1:0] read_color;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Shadow copy of the grid and of the walk bookkeeping.
  logic [gff_pkg::COLOR_W-1:0] shadow_colors [gff_pkg::CELL_COUNT];
  bit                          shadow_seen [gff_pkg::CELL_COUNT];
  int                          shadow_walk [gff_pkg::CELL_COUNT];

  outcome_t pending_words [$];
  bit       steady_flow = 1'b0;
  int       mismatches = 0;
  int       words_sent = 0;
  int       words_checked = 0;
  int       fills_sent = 0;
  int       cells_painted = 0;

  grid_flood_fill_8conn uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Breadth-first recolor from a seed cell; returns the number of cells painted.
  function automatic int flood_recolor(int seed, logic [gff_pkg::COLOR_W-1:0] paint);
    int head;
    int tail;
    int here;
    int r;
    int c;
    int nr;
    int nc;
    int k;
    int there;
    int total;
    logic [gff_pkg::COLOR_W-1:0] own;
    if (shadow_colors[seed] == paint) return 0;
    foreach (shadow_seen[i]) shadow_seen[i] = 1'b0;
    head = 0;
    tail = 1;
    total = 0;
    shadow_walk[0] = seed;
    shadow_seen[seed] = 1'b1;
    while (head < tail) begin
      here = shadow_walk[head];
      head = head + 1;
      r = here / gff_pkg::GRID_DIM;
      c = here % gff_pkg::GRID_DIM;
      own = shadow_colors[here];
      for (k = 0; k < 8; k++) begin
        nr = r + ROW_STEP[k];
        nc = c + COL_STEP[k];
        if (nr >= 0 && nr < gff_pkg::GRID_DIM && nc >= 0 && nc < gff_pkg::GRID_DIM) begin
          there = nr * gff_pkg::GRID_DIM + nc;
          if (shadow_colors[there] == own && !shadow_seen[there]) begin
            shadow_seen[there] = 1'b1;
            shadow_walk[tail] = there;
            tail = tail + 1;
          end
        end
      end
      shadow_colors[here] = paint;
      total = total + 1;
    end
    return total;
  endfunction

  // Applies one command to the shadow grid and returns the word it should produce.
  function automatic outcome_t predict_word(gff_pkg::cmd_t cmd);
    outcome_t res;
    int idx;
    res = '0;
    if (cmd.row < gff_pkg::GRID_DIM && cmd.col < gff_pkg::GRID_DIM) begin
      idx = int'(cmd.row) * gff_pkg::GRID_DIM + int'(cmd.col);
      case (cmd.mode)
        gff_pkg::MODE_WRITE: shadow_colors[idx] = cmd.color;
        gff_pkg::MODE_READ:  res.read_color = shadow_colors[idx];
        gff_pkg::MODE_FILL:
          res.filled_count = gff_pkg::COUNT_W'(flood_recolor(idx, cmd.color));
        default:             ;
      endcase
    end
    return res;
  endfunction

  // Sends one command word, after a random gap unless steady_flow is set, and queues the word it should produce.
  task automatic send_word(input logic [gff_pkg::MODE_W-1:0] mode, input int row,
                           input int col, input int color);
    gff_pkg::cmd_t cmd;
    outcome_t want;
    int gap;
    cmd.mode = mode;
    cmd.row = row[gff_pkg::COORD_W-1:0];
    cmd.col = col[gff_pkg::COORD_W-1:0];
    cmd.color = color[gff_pkg::COLOR_W-1:0];
    gap = steady_flow ? 0 : $urandom_range(12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, cmd.color, cmd.col, cmd.row, cmd.mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = predict_word(cmd);
    pending_words.push_back(want);
    words_sent++;
    if (cmd.mode == gff_pkg::MODE_FILL) begin
      fills_sent++;
      cells_painted += int'(want.filled_count);
    end
  endtask

  // Holds the input side quiet until every queued result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // Compares one accepted result word with the oldest expectation.
  function automatic void check_word(logic [15:0] w);
    outcome_t want;
    outcome_t got;
    got = '{filled_count: w[11:2], read_color: w[1:0]};
    if (pending_words.size() == 0) begin
      note_failure($sformatf("result word %h arrived with nothing expected", w));
      return;
    end
    want = pending_words.pop_front();
    if (got.read_color !== want.read_color)
      note_failure($sformatf("word %0d: read_color expected %0d, got %0d",
                             words_checked, want.read_color, got.read_color));
    if (got.filled_count !== want.filled_count)
      note_failure($sformatf("word %0d: filled_count expected %0d, got %0d",
                             words_checked, want.filled_count, got.filled_count));
    words_checked++;
  endfunction

  // Result side: random stalls unless steady_flow is set, one check per accepted word.
  initial begin : word_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      check_word(m_axis_tdata);
    end
  end

  // A fresh grid reads back as color zero at three corner cells.
  task automatic test_reset_state();
    send_word(gff_pkg::MODE_READ, 0, 0, 0);
    send_word(gff_pkg::MODE_READ, 23, 23, 3);
    send_word(gff_pkg::MODE_READ, 0, 23, 0);
  endtask

  // Commands that address cells off the grid must not alias onto real cells.
  task automatic test_off_grid();
    send_word(gff_pkg::MODE_WRITE, 24, 0, 1);
    send_word(gff_pkg::MODE_WRITE, 31, 31, 2);
    send_word(gff_pkg::MODE_READ, 31, 5, 0);
    send_word(gff_pkg::MODE_FILL, 5, 31, 2);
    send_word(gff_pkg::MODE_READ, 0, 24, 0);
    send_word(gff_pkg::MODE_READ, 0, 0, 0);
  endtask

  // The spare mode changes nothing and returns zero.
  task automatic test_unused_mode();
    send_word(MODE_SPARE, 3, 4, 3);
    send_word(MODE_SPARE, 31, 31, 3);
    send_word(gff_pkg::MODE_READ, 3, 4, 0);
  endtask

  // Color three is stored as given, and whole-grid fills reach the largest counts.
  task automatic test_color_three();
    steady_flow = 1'b1;
    send_word(gff_pkg::MODE_WRITE, 10, 10, 3);
    send_word(gff_pkg::MODE_READ, 10, 10, 0);
    send_word(gff_pkg::MODE_FILL, 0, 0, 1);
    steady_flow = 1'b0;
    send_word(gff_pkg::MODE_FILL, 10, 10, 3);
    send_word(gff_pkg::MODE_FILL, 5, 5, 3);
    send_word(gff_pkg::MODE_FILL, 0, 0, 0);
    send_word(gff_pkg::MODE_READ, 23, 23, 0);
  endtask

  // Filling with the seed's own color is skipped.
  task automatic test_same_color_fill();
    send_word(gff_pkg::MODE_FILL, 23, 23, 0);
  endtask

  // A diagonal chain is one region under 8-connectivity.
  task automatic test_diagonal_chain();
    send_word(gff_pkg::MODE_WRITE, 2, 2, 2);
    send_word(gff_pkg::MODE_WRITE, 3, 3, 2);
    send_word(gff_pkg::MODE_WRITE, 4, 4, 2);
    send_word(gff_pkg::MODE_FILL, 2, 2, 1);
    send_word(gff_pkg::MODE_READ, 4, 4, 0);
  endtask

  // Random episodes: boxed cells, scattered strokes followed by a fill, and noise.
  task automatic test_random_episodes();
    int goal;
    int kind;
    int cr;
    int cc;
    int dr;
    int dc;
    bit paused;
    logic [gff_pkg::COLOR_W-1:0] ring_c;
    goal = words_sent + 105;
    paused = 1'b0;
    while (words_sent < goal) begin
      if (!paused && words_sent > goal - 55) begin
        wait_drained();
        paused = 1'b1;
      end
      steady_flow = ($urandom_range(3) == 0);
      kind = $urandom_range(9);
      cr = $urandom_range(23);
      cc = $urandom_range(23);
      if (kind < 4) begin
        // A one-cell core inside a ring, then a fill on the core or on the ring.
        ring_c = gff_pkg::COLOR_W'($urandom_range(3));
        send_word(gff_pkg::MODE_WRITE, cr, cc, $urandom_range(3));
        for (dr = -1; dr <= 1; dr++)
          for (dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0)
              send_word(gff_pkg::MODE_WRITE, cr + dr, cc + dc, int'(ring_c));
        if ($urandom_range(1))
          send_word(gff_pkg::MODE_FILL, cr, cc, $urandom_range(3));
        else
          send_word(gff_pkg::MODE_FILL, cr - 1, cc + $urandom_range(2) - 1,
                    $urandom_range(3));
        send_word(gff_pkg::MODE_READ, cr, cc, $urandom_range(3));
      end else if (kind < 9) begin
        // A few scattered writes near a point, a fill nearby, then reads.
        repeat ($urandom_range(5, 1))
          send_word(gff_pkg::MODE_WRITE, cr + $urandom_range(4) - 2,
                    cc + $urandom_range(4) - 2, $urandom_range(3));
        send_word(gff_pkg::MODE_FILL, cr + $urandom_range(2) - 1, cc + $urandom_range(2) - 1,
                  $urandom_range(3));
        repeat ($urandom_range(2, 1))
          send_word(gff_pkg::MODE_READ, cr + $urandom_range(2) - 1,
                    cc + $urandom_range(2) - 1, $urandom_range(3));
      end else begin
        // Any mode at any coordinate the fields can carry.
        repeat (3)
          send_word(gff_pkg::MODE_W'($urandom_range(3)), $urandom_range(31),
                    $urandom_range(31), $urandom_range(3));
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    foreach (shadow_colors[i]) shadow_colors[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_off_grid();
    test_unused_mode();
    wait_drained();
    test_color_three();
    test_same_color_fill();
    test_diagonal_chain();
    wait_drained();
    test_random_episodes();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d commands including %0d fills that recolored %0d cells in all.",
             words_sent, fills_sent, cells_painted);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0)
      $display("grid_flood_fill_8conn test passed");
    else
      $display("grid_flood_fill_8conn test failed");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200_000_000;
    $display("grid_flood_fill_8conn test failed");
    $finish;
  end

endmodule

FILE: grid_flood_fill_8conn.f
rtl/gff_pkg.sv
rtl/gff_ram.sv
rtl/gff_walk.sv
rtl/grid_flood_fill_8conn.sv
test/grid_flood_fill_8conn_test.sv
